/* sv/tmig_pkg.sv */
// Shared types and constants for the triangle mesh index generator.
package tmig_pkg;

	localparam int IDX_W = 18;
	localparam int CFG_W = 8;
	localparam int COL_W = 9;
	localparam int ROW_W = 8;
	localparam int TRI_W = 3;

	// configuration register indexes
	localparam logic REG_NX        = 1'b0;
	localparam logic REG_HALF_ROWS = 1'b1;

	// region codes on the output
	localparam logic [1:0] REGION_EDGE  = 2'd0;
	localparam logic [1:0] REGION_SIDE  = 2'd1;
	localparam logic [1:0] REGION_INNER = 2'd2;

	typedef enum logic [1:0] {
		PH_EDGE  = 2'd0,
		PH_SIDE  = 2'd1,
		PH_INNER = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic               sub_phase;
		logic [ROW_W-1:0]   row_pair;
		logic [COL_W-1:0]   column;
		logic [TRI_W-1:0]   tri_in_group;
	} walk_t;

	typedef struct packed {
		walk_t              walk;
		logic [IDX_W-1:0]   row_off;
		logic               last_face;
	} stage1_t;

endpackage

/* sv/tmig_seq.sv */
// Triangle walk counters and first pipeline stage of the index generator.
module tmig_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	input  logic [tmig_pkg::CFG_W-1:0]      nx,
	input  logic [tmig_pkg::CFG_W-1:0]      half_rows,
	input  logic                            advance,
	output logic                            s1_valid,
	output tmig_pkg::stage1_t               s1
);

	tmig_pkg::walk_t   walk_q;
	tmig_pkg::walk_t   cur;
	tmig_pkg::walk_t   nxt;
	tmig_pkg::stage1_t s1_s1;
	logic              valid_s1;
	logic              wrap;
	logic              accept;
	logic [9:0]        col_inc;
	logic [9:0]        col_lim;
	logic [8:0]        row_inc;
	logic [9:0]        pair_stride;

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign pair_stride = {1'b0, nx, 1'b0} + 10'd7;
	assign col_inc = {1'b0, cur.column} + 10'd1;
	assign row_inc = {1'b0, cur.row_pair} + 9'd1;

	always_comb begin
		cur = walk_q;
		if (restart) begin
			cur = '0;
		end
		nxt  = cur;
		wrap = 1'b0;
		col_lim = 10'd0;
		unique case (cur.phase)
			tmig_pkg::PH_EDGE: begin
				if (cur.tri_in_group < 3'd3) begin
					nxt.tri_in_group = cur.tri_in_group + 3'd1;
				end else begin
					nxt.tri_in_group = '0;
					nxt.column = col_inc[tmig_pkg::COL_W-1:0];
					col_lim = {2'b00, nx} + 10'd2;
					if (col_inc >= col_lim) begin
						if (half_rows == '0) begin
							nxt  = '0;
							wrap = 1'b1;
						end else begin
							nxt = '0;
							nxt.phase = tmig_pkg::PH_SIDE;
						end
					end
				end
			end
			tmig_pkg::PH_SIDE: begin
				if (cur.tri_in_group < 3'd7) begin
					nxt.tri_in_group = cur.tri_in_group + 3'd1;
				end else begin
					nxt.tri_in_group = '0;
					nxt.row_pair = row_inc[tmig_pkg::ROW_W-1:0];
					if (row_inc >= {1'b0, half_rows}) begin
						nxt = '0;
						nxt.phase = tmig_pkg::PH_INNER;
						nxt.sub_phase = (nx == '0);
					end
				end
			end
			tmig_pkg::PH_INNER: begin
				if (cur.tri_in_group == '0) begin
					nxt.tri_in_group = 3'd1;
				end else begin
					nxt.tri_in_group = '0;
					nxt.column = col_inc[tmig_pkg::COL_W-1:0];
					col_lim = {2'b00, nx} + {9'd0, cur.sub_phase};
					if (col_inc >= col_lim) begin
						if (!cur.sub_phase) begin
							nxt.sub_phase = 1'b1;
							nxt.column = '0;
						end else if (row_inc >= {1'b0, half_rows}) begin
							nxt  = '0;
							wrap = 1'b1;
						end else begin
							nxt.row_pair = row_inc[tmig_pkg::ROW_W-1:0];
							nxt.sub_phase = (nx == '0);
							nxt.column = '0;
						end
					end
				end
			end
			default: begin
				nxt  = '0;
				wrap = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (accept) begin
				walk_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1.walk      <= cur;
			s1_s1.row_off   <= tmig_pkg::IDX_W'(cur.row_pair) *
				tmig_pkg::IDX_W'(pair_stride);
			s1_s1.last_face <= wrap;
		end
	end

	assign s1_valid = valid_s1;
	assign s1       = s1_s1;

endmodule

/* sv/tmig_idx.sv */
// Vertex index arithmetic and result register of the index generator.
module tmig_idx (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [tmig_pkg::CFG_W-1:0]      nx,
	input  logic [tmig_pkg::CFG_W-1:0]      half_rows,
	input  logic                            s1_valid,
	input  tmig_pkg::stage1_t               s1,
	output logic                            advance,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tmig_pkg::IDX_W-1:0]      vertex_a,
	output logic [tmig_pkg::IDX_W-1:0]      vertex_b,
	output logic [tmig_pkg::IDX_W-1:0]      vertex_c,
	output logic [1:0]                      region,
	output logic                            last_face
);

	logic [tmig_pkg::IDX_W-1:0] top_off_q;
	logic [tmig_pkg::IDX_W-1:0] n18;
	logic [tmig_pkg::IDX_W-1:0] col18;
	logic [tmig_pkg::IDX_W-1:0] base;
	logic [tmig_pkg::IDX_W-1:0] off_b;
	logic [tmig_pkg::IDX_W-1:0] off_c;
	logic [1:0]                 reg_sel;
	logic [1:0]                 grp;
	logic                       k;
	logic                       valid_q;
	logic [tmig_pkg::IDX_W-1:0] a_q;
	logic [tmig_pkg::IDX_W-1:0] b_q;
	logic [tmig_pkg::IDX_W-1:0] c_q;
	logic [1:0]                 region_q;
	logic                       last_q;

	assign n18   = tmig_pkg::IDX_W'(nx);
	assign col18 = tmig_pkg::IDX_W'(s1.walk.column);
	assign grp   = s1.walk.tri_in_group[2:1];
	assign k     = s1.walk.tri_in_group[0];
	assign advance = !valid_q || out_ready;

	// offset of the top boundary strip, w*(1+2h)+h
	always_ff @(posedge clk) begin
		top_off_q <= tmig_pkg::IDX_W'(({10'd0, nx} + 18'd3) *
			({9'd0, half_rows, 1'b1})) + tmig_pkg::IDX_W'(half_rows);
	end

	always_comb begin
		base    = '0;
		off_b   = '0;
		off_c   = '0;
		reg_sel = tmig_pkg::REGION_EDGE;
		unique case (s1.walk.phase)
			tmig_pkg::PH_EDGE: begin
				reg_sel = tmig_pkg::REGION_EDGE;
				base = col18 + ((grp != 2'd0) ? top_off_q : '0);
				off_b = k ? n18 + 18'd4 : 18'd1;
				off_c = k ? n18 + 18'd3 : n18 + 18'd4;
			end
			tmig_pkg::PH_SIDE: begin
				reg_sel = tmig_pkg::REGION_SIDE;
				case (grp)
					2'd0: base = n18 + 18'd3 + s1.row_off;
					2'd1: base = {n18[16:0], 1'b0} + 18'd4 + s1.row_off;
					2'd2: base = {n18[16:0], 1'b0} + 18'd6 + s1.row_off;
					default: base = {n18[16:0], 1'b0} + n18 + 18'd8 + s1.row_off;
				endcase
				if (grp == 2'd1 || grp == 2'd2) begin
					off_b = k ? n18 + 18'd5 : 18'd1;
					off_c = k ? n18 + 18'd4 : n18 + 18'd5;
				end else begin
					off_b = k ? n18 + 18'd4 : 18'd1;
					off_c = k ? n18 + 18'd3 : n18 + 18'd4;
				end
			end
			tmig_pkg::PH_INNER: begin
				reg_sel = tmig_pkg::REGION_INNER;
				if (!k) begin
					base = n18 + 18'd4 + col18 + s1.row_off;
				end else if (!s1.walk.sub_phase) begin
					base = {n18[16:0], 1'b0} + 18'd8 + col18 + s1.row_off;
				end else begin
					base = {n18[16:0], 1'b0} + 18'd7 + col18 + s1.row_off;
				end
				// up triangle when k differs from sub_phase
				if (k ^ s1.walk.sub_phase) begin
					off_b = n18 + 18'd4;
					off_c = n18 + 18'd3;
				end else begin
					off_b = 18'd1;
					off_c = n18 + 18'd4;
				end
			end
			default: begin
				base    = '0;
				reg_sel = tmig_pkg::REGION_EDGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			a_q      <= base;
			if (s1.walk.phase == tmig_pkg::PH_EDGE || s1.walk.phase == tmig_pkg::PH_SIDE ||
				s1.walk.phase == tmig_pkg::PH_INNER) begin
				b_q <= base + off_b;
				c_q <= base + off_c;
			end else begin
				b_q <= '0;
				c_q <= '0;
			end
			region_q <= reg_sel;
			last_q   <= s1.last_face;
		end
	end

	assign out_valid = valid_q;
	assign vertex_a  = a_q;
	assign vertex_b  = b_q;
	assign vertex_c  = c_q;
	assign region    = region_q;
	assign last_face = last_q;

endmodule

/* sv/triangle_mesh_index_generator.sv */
// Top level of the triangle mesh index generator.
// Each request on the slave stream yields one triangle (three vertex indices) of a
// structured mesh with a boundary ring, in the order bottom/top boundary, side
// boundary, interior; the final triangle carries tlast and the walk then wraps.
// Setting bit 0 of the request data restarts at the first triangle. One triangle
// is produced per clock while the result stream does not stall; each request is
// registered in the walk counter stage and then in the index adder stage.
// Write nx and half_rows only while no request is in flight.
module triangle_mesh_index_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tmig_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // [0] restart
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [55:0]                     m_axis_tdata,   // [17:0] a, [35:18] b, [53:36] c
	output logic [1:0]                      m_axis_tuser,   // [1:0] region
	output logic                            m_axis_tlast    // last_face
);

	logic [tmig_pkg::CFG_W-1:0]  nx_q;
	logic [tmig_pkg::CFG_W-1:0]  half_rows_q;
	logic                        advance;
	logic                        s1_valid;
	tmig_pkg::stage1_t           s1;
	logic [tmig_pkg::IDX_W-1:0]  vertex_a;
	logic [tmig_pkg::IDX_W-1:0]  vertex_b;
	logic [tmig_pkg::IDX_W-1:0]  vertex_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q        <= 8'd8;
			half_rows_q <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmig_pkg::REG_NX:        nx_q        <= cfg_data;
				tmig_pkg::REG_HALF_ROWS: half_rows_q <= cfg_data;
				default:                 nx_q        <= nx_q;
			endcase
		end
	end

	tmig_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.restart   (s_axis_tdata[0]),
		.nx        (nx_q),
		.half_rows (half_rows_q),
		.advance   (advance),
		.s1_valid  (s1_valid),
		.s1        (s1)
	);

	tmig_idx u_idx (
		.clk       (clk),
		.arst_n    (arst_n),
		.nx        (nx_q),
		.half_rows (half_rows_q),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.vertex_a  (vertex_a),
		.vertex_b  (vertex_b),
		.vertex_c  (vertex_c),
		.region    (m_axis_tuser),
		.last_face (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, vertex_c, vertex_b, vertex_a};

endmodule

/* dv/triangle_mesh_index_generator_tb.sv */
// Self-checking stream testbench for the triangle mesh index generator.
module triangle_mesh_index_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_GAP      = 17;
	localparam int RANDOM_ITEMS = 600;

	typedef struct packed {
		logic [tmig_pkg::IDX_W-1:0] vertex_a;
		logic [tmig_pkg::IDX_W-1:0] vertex_b;
		logic [tmig_pkg::IDX_W-1:0] vertex_c;
		logic [1:0]                 region;
		logic                       last_face;
	} triangle_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic                        cfg_index = tmig_pkg::REG_NX;
	logic [tmig_pkg::CFG_W-1:0]  cfg_data = '0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata = '0;    // [0] restart
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [55:0]                 m_axis_tdata;         // [17:0] a, [35:18] b, [53:36] c
	logic [1:0]                  m_axis_tuser;         // [1:0] region
	logic                        m_axis_tlast;         // last_face

	// predictor copy of the registers and of the walk
	logic [tmig_pkg::CFG_W-1:0]  mesh_nx;
	logic [tmig_pkg::CFG_W-1:0]  mesh_rows;
	tmig_pkg::walk_t             walk;

	triangle_t         expected_tris[$];
	bit                src_gaps = 1'b1;
	bit                snk_gaps = 1'b1;
	int                errors = 0;
	int                requests_sent = 0;
	int                random_sent = 0;
	int                triangles_checked = 0;
	int                wraps_seen = 0;
	int                reg_writes = 0;
	int                cycle_count = 0;

	triangle_mesh_index_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timeout with %0d triangles outstanding", expected_tris.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void walk_home();
		walk.phase        = tmig_pkg::PH_EDGE;
		walk.sub_phase    = 1'b0;
		walk.row_pair     = '0;
		walk.column       = '0;
		walk.tri_in_group = '0;
	endfunction

	function automatic void enter_inner_row(input int n);
		walk.sub_phase    = (n == 0);
		walk.column       = '0;
		walk.tri_in_group = '0;
	endfunction

	// steps the walk to the next triangle; returns 1 when the mesh wraps
	function automatic logic advance_walk(input int n, input int h);
		int next;
		int limit;
		case (walk.phase)
			tmig_pkg::PH_EDGE: begin
				if (walk.tri_in_group < 3) begin
					walk.tri_in_group = walk.tri_in_group + 1'b1;
					return 1'b0;
				end
				walk.tri_in_group = '0;
				next = walk.column + 1;
				walk.column = tmig_pkg::COL_W'(next);
				if (next < n + 2)
					return 1'b0;
				if (h == 0) begin
					walk_home();
					return 1'b1;
				end
				walk.phase    = tmig_pkg::PH_SIDE;
				walk.row_pair = '0;
				walk.column   = '0;
				return 1'b0;
			end
			tmig_pkg::PH_SIDE: begin
				if (walk.tri_in_group < 7) begin
					walk.tri_in_group = walk.tri_in_group + 1'b1;
					return 1'b0;
				end
				walk.tri_in_group = '0;
				next = walk.row_pair + 1;
				walk.row_pair = tmig_pkg::ROW_W'(next);
				if (next < h)
					return 1'b0;
				walk.phase    = tmig_pkg::PH_INNER;
				walk.row_pair = '0;
				enter_inner_row(n);
				return 1'b0;
			end
			tmig_pkg::PH_INNER: begin
				if (walk.tri_in_group == 0) begin
					walk.tri_in_group = 3'd1;
					return 1'b0;
				end
				walk.tri_in_group = '0;
				next = walk.column + 1;
				walk.column = tmig_pkg::COL_W'(next);
				limit = walk.sub_phase ? n + 1 : n;
				if (next < limit)
					return 1'b0;
				if (!walk.sub_phase) begin
					walk.sub_phase = 1'b1;
					walk.column    = '0;
					return 1'b0;
				end
				next = walk.row_pair + 1;
				walk.row_pair = tmig_pkg::ROW_W'(next);
				if (next >= h) begin
					walk_home();
					return 1'b1;
				end
				enter_inner_row(n);
				return 1'b0;
			end
			default: begin
				walk_home();
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic triangle_t next_triangle(input logic restart);
		triangle_t t;
		int n, h, w, j, base, db, dc, b_idx, c_idx;
		logic k;
		logic [1:0] g;
		logic down;
		if (restart)
			walk_home();
		n = mesh_nx;
		h = mesh_rows;
		w = n + 3;
		j = walk.row_pair * (2 * n + 7);
		k = walk.tri_in_group[0];
		g = walk.tri_in_group[2:1];
		t.region = walk.phase;
		case (walk.phase)
			tmig_pkg::PH_EDGE: begin
				base = walk.column + ((g != 0) ? w * (1 + 2 * h) + h : 0);
				db = k ? w + 1 : 1;
				dc = k ? w : w + 1;
			end
			tmig_pkg::PH_SIDE: begin
				case (g)
					2'd0: base = w + j;
					2'd1: base = 2 * n + 4 + j;
					2'd2: base = 2 * n + 6 + j;
					default: base = 3 * n + 8 + j;
				endcase
				if (g == 2'd1 || g == 2'd2) begin
					db = k ? n + 5 : 1;
					dc = k ? n + 4 : n + 5;
				end else begin
					db = k ? n + 4 : 1;
					dc = k ? n + 3 : n + 4;
				end
			end
			default: begin
				if (!walk.sub_phase) begin
					base = (k ? 2 * n + 8 : n + 4) + walk.column + j;
					down = !k;
				end else begin
					base = (k ? 2 * n + 7 : n + 4) + walk.column + j;
					down = k;
				end
				db = down ? 1 : n + 4;
				dc = down ? n + 4 : n + 3;
			end
		endcase
		b_idx = base + db;
		c_idx = base + dc;
		t.vertex_a  = base[tmig_pkg::IDX_W-1:0];
		t.vertex_b  = b_idx[tmig_pkg::IDX_W-1:0];
		t.vertex_c  = c_idx[tmig_pkg::IDX_W-1:0];
		t.last_face = advance_walk(n, h);
		return t;
	endfunction

	// newest expected triangle at the front, oldest at the back
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_tris.push_front(next_triangle(s_axis_tdata[0]));
	end

	always @(posedge clk) begin
		triangle_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_tris.size() == 0) begin
				$error("triangle with no request pending: tdata %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_tris.pop_back();
				triangles_checked++;
				if (want.last_face)
					wraps_seen++;
				if (m_axis_tdata[17:0] !== want.vertex_a) begin
					$error("vertex_a: expected %0d, got %0d", want.vertex_a, m_axis_tdata[17:0]);
					errors++;
				end
				if (m_axis_tdata[35:18] !== want.vertex_b) begin
					$error("vertex_b: expected %0d, got %0d", want.vertex_b, m_axis_tdata[35:18]);
					errors++;
				end
				if (m_axis_tdata[53:36] !== want.vertex_c) begin
					$error("vertex_c: expected %0d, got %0d", want.vertex_c, m_axis_tdata[53:36]);
					errors++;
				end
				if (m_axis_tuser !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== want.last_face) begin
					$error("last_face: expected %0d, got %0d", want.last_face, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// result side: random stall before each result
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = snk_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_request(input logic restart);
		int gap;
		gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, restart};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_tris.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [tmig_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tmig_pkg::REG_NX)
			mesh_nx = value;
		else
			mesh_rows = value;
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic configure(input logic [tmig_pkg::CFG_W-1:0] nx_val,
		input logic [tmig_pkg::CFG_W-1:0] rows_val);
		write_reg(tmig_pkg::REG_NX, nx_val);
		write_reg(tmig_pkg::REG_HALF_ROWS, rows_val);
	endtask

	task automatic test_reset_state();
		send_request(1'b0);
		send_request(1'b1);
		wait_idle();
	endtask

	// no row pairs: boundary ring only, last top triangle flagged, then wrap
	task automatic test_zero_rows();
		configure(8'd0, 8'd0);
		send_request(1'b1);
		repeat (8) send_request(1'b0);
		wait_idle();
	endtask

	// no columns: the down-first interior run is skipped
	task automatic test_zero_columns();
		configure(8'd0, 8'd1);
		send_request(1'b1);
		repeat (17) send_request(1'b0);
		wait_idle();
	endtask

	task automatic test_extremes();
		configure(8'd255, 8'd255);
		send_request(1'b1);
		repeat (3) send_request(1'b0);
		send_request(1'b1);
		wait_idle();
	endtask

	// segments of random requests; registers change mid-walk without restart
	task automatic test_random_walks();
		int seg_len;
		logic [tmig_pkg::CFG_W-1:0] nx_val;
		logic [tmig_pkg::CFG_W-1:0] rows_val;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: nx_val = 8'd255;
					1: nx_val = $urandom_range(0, 255);
					2: nx_val = 8'd1;
					default: nx_val = $urandom_range(0, 5);
				endcase
				case ($urandom_range(0, 9))
					0: rows_val = 8'd255;
					1: rows_val = $urandom_range(0, 255);
					default: rows_val = $urandom_range(0, 3);
				endcase
				configure(nx_val, rows_val);
			end
			src_gaps = ($urandom_range(0, 3) != 0);
			snk_gaps = ($urandom_range(0, 3) != 0);
			seg_len = $urandom_range(10, 40);
			repeat (seg_len) send_request($urandom_range(0, 19) == 0);
			random_sent += seg_len;
			wait_idle();
		end
	endtask

	initial begin
		mesh_nx   = 8'd8;
		mesh_rows = 8'd4;
		walk_home();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_zero_rows();
		test_zero_columns();
		test_extremes();
		test_random_walks();
		wait_idle();
		repeat (8) @(posedge clk);
		if (expected_tris.size() != 0) begin
			$error("%0d triangles never arrived", expected_tris.size());
			errors++;
		end
		$display("Sent %0d requests (%0d random) across %0d register writes,",
			requests_sent, random_sent, reg_writes);
		$display("checked %0d triangles and %0d mesh wraps.", triangles_checked, wraps_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* triangle_mesh_index_generator.f */
sv/tmig_pkg.sv
sv/tmig_seq.sv
sv/tmig_idx.sv
sv/triangle_mesh_index_generator.sv
dv/triangle_mesh_index_generator_tb.sv
